FILE: hw/rtl/sigder_pkg.sv
// shared types and constants for the signature DER encoder
// no dependencies; used by sigder_seq, sigder_pack and the top level
package sigder_pkg;

    // DER tags and fixed bytes
    localparam logic [7:0] TAG_SEQUENCE = 8'h30;
    localparam logic [7:0] TAG_INTEGER  = 8'h02;
    localparam logic [7:0] PAD_BYTE     = 8'h00;
    localparam logic [7:0] SIGN_BIT     = 8'h80;
    localparam logic [7:0] LEN_MASK     = 8'h7F;

    // sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_HDR_SEQ,
        S_HDR_LEN,
        S_INT_TAG,
        S_INT_LEN,
        S_INT_PAD,
        S_DATA_RD,
        S_DATA
    } seq_state_t;

    // one DER byte handed from the sequencer to the packer
    typedef struct packed {
        logic       vld;
        logic       last;
        logic [7:0] data;
    } der_byte_t;

endpackage

FILE: hw/rtl/ecdsa_sig_der_encoder_core.sv
// top level of the ECDSA signature DER encoder
// depends on sigder_pkg, sigder_ram, sigder_seq and sigder_pack
//
// Signature words are written with start while busy is low: r words first,
// then s words, ceil(COORD_BYTES/8) words each, one word per cycle. Every
// word but the last of s leaves busy low. The last word launches the
// encoding and holds busy high until the final DER byte is out. The word
// store has a single read port: the leading zero scan fetches a word, then
// checks it, and the DER stream leaves one byte per cycle but for a fetch
// at each word boundary. Results appear on result_strobe for one cycle
// each, eight bytes per word, up to nine words; the receiver must take
// each one as it comes.
module ecdsa_sig_der_encoder_core
    import sigder_pkg::*;
#(
    parameter int COORD_BYTES = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [63:0] sig_word,
    output logic [63:0] der_word,
    output logic [3:0]  valid_bytes,
    output logic        last_word,
    output logic        result_strobe
);

    localparam int SIG_WORDS = 2 * ((COORD_BYTES + 7) / 8);
    localparam int AW        = $clog2(SIG_WORDS);

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [63:0]   wr_data;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [63:0]   rd_data;
    der_byte_t     der_byte;

    // signature word store
    sigder_ram #(
        .WIDTH (64),
        .DEPTH (SIG_WORDS)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // scan and byte stream sequencer
    sigder_seq #(
        .COORD_BYTES (COORD_BYTES)
    ) u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .sig_word (sig_word),
        .busy     (busy),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .rd_data  (rd_data),
        .byte_out (der_byte)
    );

    // word packer and result register
    sigder_pack u_pack (
        .clk           (clk),
        .rst_n         (rst_n),
        .byte_in       (der_byte),
        .der_word      (der_word),
        .valid_bytes   (valid_bytes),
        .last_word     (last_word),
        .result_strobe (result_strobe)
    );

endmodule

FILE: hw/rtl/sigder_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module sigder_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port, data holds between reads
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: hw/rtl/sigder_seq.sv
// sequencer (needs sigder_pkg): stores signature words, scans coordinates
// for leading zeros, then walks DER bytes one a cycle except at word reads
module sigder_seq
    import sigder_pkg::*;
#(
    parameter int COORD_BYTES = 32
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        start,
    input  logic [63:0]                                 sig_word,
    output logic                                        busy,
    output logic                                        wr_en,
    output logic [$clog2(2*((COORD_BYTES+7)/8))-1:0]    wr_addr,
    output logic [63:0]                                 wr_data,
    output logic                                        rd_en,
    output logic [$clog2(2*((COORD_BYTES+7)/8))-1:0]    rd_addr,
    input  logic [63:0]                                 rd_data,
    output der_byte_t                                   byte_out
);

    localparam int WPC       = (COORD_BYTES + 7) / 8;
    localparam int SIG_WORDS = 2 * WPC;
    localparam int LAST_N    = COORD_BYTES - 8 * (WPC - 1);
    localparam int AW        = $clog2(SIG_WORDS);
    localparam int WW        = (WPC > 1) ? $clog2(WPC) : 1;
    localparam int IW        = $clog2(COORD_BYTES);

    seq_state_t          state_reg, state_next;
    logic [AW-1:0]       wc_reg, wc_next;
    logic                coord_reg, coord_next;
    logic [WW-1:0]       widx_reg, widx_next;
    logic [IW-1:0]       bidx_reg, bidx_next;
    logic [1:0][IW-1:0]  off_reg, off_next;
    logic [1:0]          pad_reg, pad_next;

    logic                found;
    logic [2:0]          lz;
    logic                msb;
    logic [3:0]          lane_cnt;
    logic [63:0]         lane_shift;
    logic [7:0]          data_byte;
    logic [7:0]          ilen0, ilen1, ilen_cur, seq_len;
    logic [AW-1:0]       coord_base;
    logic                last_word_in;
    logic                last_byte;

    // leading zero byte search over the valid lanes of the fetched word
    assign lane_cnt = (widx_reg == WW'(WPC - 1)) ? 4'(LAST_N) : 4'd8;

    always_comb
    begin
        found = 1'b0;
        lz    = '0;
        msb   = 1'b0;
        for (int k = 0; k < 8; k++)
        begin
            if (!found && (4'(k) < lane_cnt) && (rd_data[63-8*k -: 8] != 8'h00))
            begin
                found = 1'b1;
                lz    = 3'(k);
                msb   = (rd_data[63-8*k -: 8] & SIGN_BIT) != 8'h00;
            end
        end
    end

    // lengths: integer content plus optional pad, then the sequence body
    assign ilen0    = 8'(COORD_BYTES) - 8'(off_reg[0]) + 8'(pad_reg[0]);
    assign ilen1    = 8'(COORD_BYTES) - 8'(off_reg[1]) + 8'(pad_reg[1]);
    assign ilen_cur = coord_reg ? ilen1 : ilen0;
    assign seq_len  = (8'd4 + ilen0 + ilen1) & LEN_MASK;

    // byte of the current coordinate out of the held read word
    assign lane_shift = rd_data << {bidx_reg[2:0], 3'b000};
    assign data_byte  = lane_shift[63:56];
    assign coord_base = coord_reg ? AW'(WPC) : '0;

    assign last_word_in = (wc_reg == AW'(SIG_WORDS - 1));
    assign last_byte    = (bidx_reg == IW'(COORD_BYTES - 1));

    // state and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            wc_reg    <= '0;
            coord_reg <= 1'b0;
            widx_reg  <= '0;
            bidx_reg  <= '0;
            off_reg   <= '0;
            pad_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            wc_reg    <= wc_next;
            coord_reg <= coord_next;
            widx_reg  <= widx_next;
            bidx_reg  <= bidx_next;
            off_reg   <= off_next;
            pad_reg   <= pad_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        wc_next    = wc_reg;
        coord_next = coord_reg;
        widx_next  = widx_reg;
        bidx_next  = bidx_reg;
        off_next   = off_reg;
        pad_next   = pad_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (last_word_in)
                    begin
                        wc_next    = '0;
                        coord_next = 1'b0;
                        widx_next  = '0;
                        state_next = S_SCAN_RD;
                    end
                    else
                    begin
                        wc_next = wc_reg + 1'b1;
                    end
                end
            end
            S_SCAN_RD:
            begin
                state_next = S_SCAN_CHK;
            end
            S_SCAN_CHK:
            begin
                if (found || (widx_reg == WW'(WPC - 1)))
                begin
                    off_next[coord_reg] = found ? IW'({widx_reg, lz}) : IW'(COORD_BYTES - 1);
                    pad_next[coord_reg] = found & msb;
                    widx_next           = '0;
                    if (!coord_reg)
                    begin
                        coord_next = 1'b1;
                        state_next = S_SCAN_RD;
                    end
                    else
                    begin
                        coord_next = 1'b0;
                        state_next = S_HDR_SEQ;
                    end
                end
                else
                begin
                    widx_next  = widx_reg + 1'b1;
                    state_next = S_SCAN_RD;
                end
            end
            S_HDR_SEQ:
            begin
                state_next = S_HDR_LEN;
            end
            S_HDR_LEN:
            begin
                state_next = S_INT_TAG;
            end
            S_INT_TAG:
            begin
                state_next = S_INT_LEN;
            end
            S_INT_LEN:
            begin
                bidx_next  = off_reg[coord_reg];
                state_next = pad_reg[coord_reg] ? S_INT_PAD : S_DATA_RD;
            end
            S_INT_PAD:
            begin
                state_next = S_DATA_RD;
            end
            S_DATA_RD:
            begin
                state_next = S_DATA;
            end
            S_DATA:
            begin
                if (last_byte)
                begin
                    if (!coord_reg)
                    begin
                        coord_next = 1'b1;
                        state_next = S_INT_TAG;
                    end
                    else
                    begin
                        coord_next = 1'b0;
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    bidx_next = bidx_reg + 1'b1;
                    if (bidx_reg[2:0] == 3'd7)
                    begin
                        state_next = S_DATA_RD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // outputs: memory ports and the byte stream
    always_comb
    begin
        busy     = (state_reg != S_IDLE);
        wr_en    = 1'b0;
        wr_addr  = wc_reg;
        wr_data  = sig_word;
        rd_en    = 1'b0;
        rd_addr  = coord_base + AW'(widx_reg);
        byte_out = '0;
        case (state_reg)
            S_IDLE:
            begin
                wr_en = start;
            end
            S_SCAN_RD:
            begin
                rd_en = 1'b1;
            end
            S_HDR_SEQ:
            begin
                byte_out.vld  = 1'b1;
                byte_out.data = TAG_SEQUENCE;
            end
            S_HDR_LEN:
            begin
                byte_out.vld  = 1'b1;
                byte_out.data = seq_len;
            end
            S_INT_TAG:
            begin
                byte_out.vld  = 1'b1;
                byte_out.data = TAG_INTEGER;
            end
            S_INT_LEN:
            begin
                byte_out.vld  = 1'b1;
                byte_out.data = ilen_cur;
            end
            S_INT_PAD:
            begin
                byte_out.vld  = 1'b1;
                byte_out.data = PAD_BYTE;
            end
            S_DATA_RD:
            begin
                rd_en   = 1'b1;
                rd_addr = coord_base + AW'(bidx_reg >> 3);
            end
            S_DATA:
            begin
                byte_out.vld  = 1'b1;
                byte_out.last = coord_reg & last_byte;
                byte_out.data = data_byte;
            end
            default:
            begin
                byte_out = '0;
            end
        endcase
    end

    // a check always follows a scan fetch
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN_CHK) |-> ($past(state_reg) == S_SCAN_RD))
        else $error("scan check without a preceding fetch");

    // the final byte closes the encoding and returns to idle
    assert property (@(posedge clk) disable iff (!rst_n)
        byte_out.last |=> (state_reg == S_IDLE))
        else $error("final byte did not end the encoding");

endmodule

FILE: hw/rtl/sigder_pack.sv
// packer: gathers DER bytes eight to a word, first byte in the top lane
// depends on sigder_pkg
module sigder_pack
    import sigder_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  der_byte_t   byte_in,
    output logic [63:0] der_word,
    output logic [3:0]  valid_bytes,
    output logic        last_word,
    output logic        result_strobe
);

    logic [63:0] pack_reg, pack_next;
    logic [2:0]  cnt_reg, cnt_next;
    logic [63:0] word_reg, word_next;
    logic [3:0]  vb_reg, vb_next;
    logic        last_reg, last_next;
    logic        strobe_reg, strobe_next;
    logic [63:0] merged;

    // place the incoming byte in the next free lane
    assign merged = pack_reg | ({byte_in.data, 56'h0} >> {cnt_reg, 3'b000});

    always_comb
    begin
        pack_next   = pack_reg;
        cnt_next    = cnt_reg;
        word_next   = word_reg;
        vb_next     = vb_reg;
        last_next   = last_reg;
        strobe_next = 1'b0;
        if (byte_in.vld)
        begin
            if ((cnt_reg == 3'd7) || byte_in.last)
            begin
                word_next   = merged;
                vb_next     = {1'b0, cnt_reg} + 4'd1;
                last_next   = byte_in.last;
                strobe_next = 1'b1;
                pack_next   = '0;
                cnt_next    = '0;
            end
            else
            begin
                pack_next = merged;
                cnt_next  = cnt_reg + 3'd1;
            end
        end
    end

    // lane accumulator and result control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pack_reg   <= '0;
            cnt_reg    <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            pack_reg   <= pack_next;
            cnt_reg    <= cnt_next;
            strobe_reg <= strobe_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
        vb_reg   <= vb_next;
        last_reg <= last_next;
    end

    assign der_word      = word_reg;
    assign valid_bytes   = vb_reg;
    assign last_word     = last_reg;
    assign result_strobe = strobe_reg;

    // every word but the final one is full
    assert property (@(posedge clk) disable iff (!rst_n)
        (strobe_reg && !last_reg) |-> (vb_reg == 4'd8))
        else $error("partial word before the end of the encoding");

    // byte count of a result stays in one to eight
    assert property (@(posedge clk) disable iff (!rst_n)
        strobe_reg |-> ((vb_reg != 4'd0) && (vb_reg <= 4'd8)))
        else $error("byte count out of range");

    // the final word is never followed at once by another
    assert property (@(posedge clk) disable iff (!rst_n)
        (strobe_reg && last_reg) |=> !strobe_reg)
        else $error("result right after the final word");

endmodule

FILE: tb/ecdsa_sig_der_encoder_core_tb.sv
// self-checking testbench for the ECDSA signature DER encoder core
// depends on sigder_pkg and ecdsa_sig_der_encoder_core; predicts each DER word in
// a behavioral encoder and compares it against every result_strobe transfer
module ecdsa_sig_der_encoder_core_tb;
    import sigder_pkg::*;

    localparam int COORD_BYTES    = 32;
    localparam int WPC            = (COORD_BYTES + 7) / 8;
    localparam int SIG_WORDS      = 2 * WPC;
    localparam int COORD_BITS     = WPC * 64;
    localparam int DER_MAX        = 2 * COORD_BYTES + 8;
    localparam int DRAIN_CYCLES   = 2 * COORD_BYTES + 6 * WPC + 16;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int RANDOM_SIGS    = 48;

    typedef struct {
        logic [63:0] data;
        logic [3:0]  nbytes;
        logic        is_last;
    } der_out_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [63:0] sig_word;
    logic [63:0] der_word;
    logic [3:0]  valid_bytes;
    logic        last_word;
    logic        result_strobe;

    // predictor state
    logic [63:0] sig_store [SIG_WORDS];
    int          sig_fill;
    der_out_t    der_words_due [$];

    // sender pacing
    int burst_left;
    bit no_gaps;

    // bookkeeping
    int mismatches;
    int words_sent;
    int sigs_sent;
    int der_words_checked;
    int idle_cycles;

    ecdsa_sig_der_encoder_core #(
        .COORD_BYTES(COORD_BYTES)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .sig_word     (sig_word),
        .der_word     (der_word),
        .valid_bytes  (valid_bytes),
        .last_word    (last_word),
        .result_strobe(result_strobe)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // byte idx of coordinate c (0 = r, 1 = s), big-endian across its words
    function automatic logic [7:0] coord_byte(input int c, input int idx);
        return sig_store[c * WPC + idx / 8][(7 - idx % 8) * 8 +: 8];
    endfunction

    // store one signature word; on the final word build the DER stream
    function automatic void der_encode_step(input logic [63:0] w);
        logic [7:0]  der_bytes [DER_MAX];
        logic [63:0] packed_word;
        der_out_t    item;
        int          pos;
        int          off;
        int          len;
        int          nwords;
        int          nvalid;
        bit          pad;

        sig_store[sig_fill] = w;
        if (sig_fill < SIG_WORDS - 1)
        begin
            sig_fill++;
            return;
        end
        sig_fill = 0;

        foreach (der_bytes[i])
            der_bytes[i] = 8'h00;
        pos = 2;
        for (int c = 0; c < 2; c++)
        begin
            // strip leading zeros but keep one byte, pad if the sign bit is set
            off = 0;
            while (off < COORD_BYTES - 1 && coord_byte(c, off) == 8'h00)
                off++;
            len = COORD_BYTES - off;
            pad = (coord_byte(c, off) & SIGN_BIT) != 8'h00;
            der_bytes[pos] = TAG_INTEGER;
            pos++;
            der_bytes[pos] = 8'(len + int'(pad));
            pos++;
            if (pad)
            begin
                der_bytes[pos] = PAD_BYTE;
                pos++;
            end
            for (int i = 0; i < len; i++)
            begin
                der_bytes[pos] = coord_byte(c, off + i);
                pos++;
            end
        end
        der_bytes[0] = TAG_SEQUENCE;
        der_bytes[1] = 8'(pos - 2) & LEN_MASK;

        // pack eight bytes per word, first byte in the top lane
        nwords = (pos + 7) / 8;
        for (int k = 0; k < nwords; k++)
        begin
            nvalid = pos - k * 8;
            if (nvalid > 8)
                nvalid = 8;
            packed_word = '0;
            for (int lane = 0; lane < nvalid; lane++)
                packed_word[63 - 8 * lane -: 8] = der_bytes[k * 8 + lane];
            item.data    = packed_word;
            item.nbytes  = 4'(nvalid);
            item.is_last = (k == nwords - 1);
            der_words_due.push_back(item);
        end
    endfunction

    // random coordinate with a mix of stripping and padding shapes
    function automatic logic [COORD_BITS-1:0] random_coord();
        logic [COORD_BITS-1:0] v;
        int                    mode;
        int                    z;

        for (int i = 0; i < COORD_BITS / 32; i++)
            v[i * 32 +: 32] = $urandom;
        mode = $urandom_range(0, 9);
        z    = 0;
        if (mode == 6)
            z = $urandom_range(1, 3);
        else if (mode == 7)
            z = $urandom_range(4, COORD_BYTES);
        else if (mode >= 8)
            z = $urandom_range(0, COORD_BYTES - 1);
        v = v & ({COORD_BITS{1'b1}} >> (8 * z));
        // force or clear the sign bit of the first kept byte
        if (mode == 8)
            v[COORD_BITS - 1 - 8 * z] = 1'b1;
        else if (mode == 9)
        begin
            v[COORD_BITS - 1 - 8 * z] = 1'b0;
            v[COORD_BITS - 8 - 8 * z] = 1'b1;
        end
        return v;
    endfunction

    // one input transfer; start stays high through a burst
    task automatic send_word(input logic [63:0] w);
        start    <= 1'b1;
        sig_word <= w;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        der_encode_step(w);
        words_sent++;
        if (no_gaps || burst_left > 0)
        begin
            if (burst_left > 0)
                burst_left--;
        end
        else
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 10))
                @(posedge clk);
            burst_left = $urandom_range(0, 12);
        end
    endtask

    task automatic send_signature(input logic [COORD_BITS-1:0] r,
                                  input logic [COORD_BITS-1:0] s);
        for (int i = 0; i < WPC; i++)
            send_word(r[COORD_BITS - 1 - 64 * i -: 64]);
        for (int i = 0; i < WPC; i++)
            send_word(s[COORD_BITS - 1 - 64 * i -: 64]);
        sigs_sent++;
    endtask

    // hold the sender until every predicted word has come out and busy drops
    task automatic wait_results();
        start <= 1'b0;
        @(posedge clk);
        while (der_words_due.size() != 0 || busy)
            @(posedge clk);
    endtask

    // all-zero and all-one signatures: shortest and longest encodings
    task automatic test_extremes();
        send_signature('0, '0);
        send_signature('1, '1);
    endtask

    // single byte with sign bit, and one stripped zero ahead of a clear sign bit
    task automatic test_strip_pad();
        logic [COORD_BITS-1:0] s;

        s = random_coord();
        s[COORD_BITS - 1 -: 16] = 16'h007F;
        send_signature({{(COORD_BITS - 8){1'b0}}, 8'h80}, s);
    endtask

    // random signatures with a mid-run pause and a stretch with no gaps
    task automatic test_random_sigs();
        for (int n = 0; n < RANDOM_SIGS; n++)
        begin
            if (n == RANDOM_SIGS / 3)
                wait_results();
            no_gaps = (n >= RANDOM_SIGS / 2 && n < RANDOM_SIGS / 2 + 8);
            send_signature(random_coord(), random_coord());
        end
        no_gaps = 1'b0;
    endtask

    // result checker
    always @(posedge clk)
    begin
        der_out_t exp_item;

        if (rst_n && result_strobe)
        begin
            if (der_words_due.size() == 0)
            begin
                $error("unexpected result transfer: der_word %h", der_word);
                mismatches++;
            end
            else
            begin
                exp_item = der_words_due.pop_front();
                der_words_checked++;
                if (der_word !== exp_item.data)
                begin
                    $error("der_word mismatch: expected %h, got %h",
                           exp_item.data, der_word);
                    mismatches++;
                end
                if (valid_bytes !== exp_item.nbytes)
                begin
                    $error("valid_bytes mismatch: expected %0d, got %0d",
                           exp_item.nbytes, valid_bytes);
                    mismatches++;
                end
                if (last_word !== exp_item.is_last)
                begin
                    $error("last_word mismatch: expected %b, got %b",
                           exp_item.is_last, last_word);
                    mismatches++;
                end
            end
        end
    end

    // watchdog on cycles with no transfer on either side
    always @(posedge clk)
    begin
        if ((start && !busy) || result_strobe)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("timeout after %0d idle cycles", idle_cycles);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // test sequence
    initial
    begin
        rst_n             = 1'b0;
        start             = 1'b0;
        sig_word          = '0;
        sig_fill          = 0;
        burst_left        = 0;
        no_gaps           = 1'b0;
        mismatches        = 0;
        words_sent        = 0;
        sigs_sent         = 0;
        der_words_checked = 0;
        foreach (sig_store[i])
            sig_store[i] = '0;

        repeat (10)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_extremes();
        test_strip_pad();
        test_random_sigs();

        wait_results();
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        $display("sent %0d signature words in %0d signatures, checked %0d DER words",
                 words_sent, sigs_sent, der_words_checked);
        $display("covered zero, full-width, stripped and padded coordinates");
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
